[rtl/thsm_pkg.sv]
// ----------------------------------------------------------------------------
// Token handover state machine package
// Transaction types, command and state codes, and small decode functions
// shared by the token handover logic.
// ----------------------------------------------------------------------------
package thsm_pkg;

   // Command codes carried in the request transaction.
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_REQUEST   = 3'd3,
      CMD_ACK       = 3'd4,
      CMD_CANCEL    = 3'd5,
      CMD_FORCE_IN  = 3'd6,
      CMD_FORCE_OUT = 3'd7
   } cmd_type;

   // Handover kinds.
   localparam logic [1:0] KIND_TAKE_OUT  = 2'd0;
   localparam logic [1:0] KIND_TAKE_IN   = 2'd1;
   localparam logic [1:0] KIND_ORDER_OUT = 2'd2;
   localparam logic [1:0] KIND_ORDER_IN  = 2'd3;
   localparam int         NUM_KINDS      = 4;

   // Reported peer state codes.
   localparam logic [2:0] PEER_DISABLED    = 3'd0;
   localparam logic [2:0] PEER_WITH        = 3'd1;
   localparam logic [2:0] PEER_WITHOUT     = 3'd2;
   localparam logic [2:0] PEER_PEND_TO     = 3'd3;
   localparam logic [2:0] PEER_PEND_TI     = 3'd4;
   localparam logic [2:0] PEER_PEND_OO     = 3'd5;
   localparam logic [2:0] PEER_PEND_OI     = 3'd6;

   // Latched error codes.
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_INNER        = 3'd1;
   localparam logic [2:0] ERR_TIMEOUT_BASE = 3'd2;

   // Heartbeat report codes.
   localparam logic [1:0] HB_NONE   = 2'd0;
   localparam logic [1:0] HB_SLAVE  = 2'd1;
   localparam logic [1:0] HB_MASTER = 2'd2;

   localparam logic [15:0] HB_INTERVAL_RESET = 16'd1000;

   // Station state machine, one-hot.
   typedef enum logic [6:0] {
      ST_DISABLED = 7'b0000001,
      ST_WITH     = 7'b0000010,
      ST_WITHOUT  = 7'b0000100,
      ST_PEND_TO  = 7'b0001000,
      ST_PEND_TI  = 7'b0010000,
      ST_PEND_OO  = 7'b0100000,
      ST_PEND_OI  = 7'b1000000
   } state_type;

   // Request transaction payload.
   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  kind;
      logic [30:0] timeout_ticks;
      logic        target_valid;
      logic        bind_ok;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic       accepted;
      logic [2:0] peer_state;
      logic [2:0] error_code;
      logic       has_token;
      logic [1:0] heartbeat;
   } rsp_type;

   // Control from the station logic to the handover timer bank.
   typedef struct packed {
      logic       tick;
      logic       load;
      logic [1:0] kind;
   } timer_ctl_type;

   // Pending state that belongs to a handover kind.
   function automatic state_type pend_state(input logic [1:0] kind);
      state_type result;
      case (kind)
         KIND_TAKE_OUT:  result = ST_PEND_TO;
         KIND_TAKE_IN:   result = ST_PEND_TI;
         KIND_ORDER_OUT: result = ST_PEND_OO;
         KIND_ORDER_IN:  result = ST_PEND_OI;
         default:        result = ST_PEND_TO;
      endcase
      return result;
   endfunction

   // Out kinds hand the token away; in kinds bring it back.
   function automatic logic kind_is_out(input logic [1:0] kind);
      return ~kind[0];
   endfunction

   // Timeout error code of a handover kind.
   function automatic logic [2:0] timeout_error(input logic [1:0] kind);
      return ERR_TIMEOUT_BASE + {1'b0, kind};
   endfunction

   // Reported code of a station state.
   function automatic logic [2:0] peer_code(input state_type st);
      logic [2:0] result;
      case (st)
         ST_DISABLED: result = PEER_DISABLED;
         ST_WITH:     result = PEER_WITH;
         ST_WITHOUT:  result = PEER_WITHOUT;
         ST_PEND_TO:  result = PEER_PEND_TO;
         ST_PEND_TI:  result = PEER_PEND_TI;
         ST_PEND_OO:  result = PEER_PEND_OO;
         ST_PEND_OI:  result = PEER_PEND_OI;
         default:     result = PEER_DISABLED;
      endcase
      return result;
   endfunction

   // The token is held while with token or while an out handover pends.
   function automatic logic holds_token(input state_type st);
      return (st == ST_WITH) || (st == ST_PEND_TO) || (st == ST_PEND_OO);
   endfunction

endpackage

[rtl/token_handover_state_machine.sv]
// ----------------------------------------------------------------------------
// Token handover state machine
// Token state of one station with guarded commands, handover timeouts and
// heartbeat pacing.
// ----------------------------------------------------------------------------
// Each request transaction is a command that is applied to the station state
// in the cycle it is accepted; its response transaction appears in the
// output register on the next cycle. One transaction is taken every cycle while
// req_stall is low, so the throughput is one transaction per clock. The
// only thing that holds the input back is a stalled response: while the
// output register holds a response that is not taken, req_stall is high.
// The handover timeouts count in tick commands, not in clock cycles, and
// TIMEOUT_WIDTH sets the width of the four countdowns. The heartbeat interval
// register may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module token_handover_state_machine #(
   parameter int TIMEOUT_WIDTH = 31
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  thsm_pkg::req_type req_data,
   // Response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output thsm_pkg::rsp_type rsp_data,
   // Configuration port
   input  logic              csr_write_enable,
   input  logic [15:0]       csr_write_data
);

   localparam int LOAD_WIDTH = (TIMEOUT_WIDTH < 31) ? TIMEOUT_WIDTH : 31;

   thsm_pkg::state_type      state_ff, state_in;
   logic [2:0]               error_ff, error_in;
   logic [15:0]              hb_count_ff, hb_count_in;
   logic                     hb_running_ff, hb_running_in;
   logic [15:0]              hb_interval_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   thsm_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     accept;
   thsm_pkg::timer_ctl_type  timer_ctl;
   logic [TIMEOUT_WIDTH-1:0] load_value;
   logic [thsm_pkg::NUM_KINDS-1:0] expired;
   logic                     acc;
   logic [1:0]               hb;
   logic [15:0]              hb_limit;
   logic [15:0]              hb_next;
   thsm_pkg::state_type      pend, home, away;

   // Input handshake: hold off only while a response waits downstream.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Timeout value masked to the countdown width.
   always_comb begin
      load_value = '0;
      load_value[LOAD_WIDTH-1:0] = req_data.timeout_ticks[LOAD_WIDTH-1:0];
   end

   assign pend = thsm_pkg::pend_state(req_data.kind);
   assign home = thsm_pkg::kind_is_out(req_data.kind) ? thsm_pkg::ST_WITH
                                                      : thsm_pkg::ST_WITHOUT;
   assign away = thsm_pkg::kind_is_out(req_data.kind) ? thsm_pkg::ST_WITHOUT
                                                      : thsm_pkg::ST_WITH;

   // Timer control: ticks run the countdowns, a granted request may arm one.
   always_comb begin
      timer_ctl.tick = accept && (req_data.cmd == thsm_pkg::CMD_TICK);
      timer_ctl.load = accept && (req_data.cmd == thsm_pkg::CMD_REQUEST)
                       && (state_ff == home) && req_data.target_valid
                       && (load_value != '0);
      timer_ctl.kind = req_data.kind;
   end

   thsm_timers #(
      .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
   ) u_timers (
      .clock      (clock),
      .reset      (reset),
      .ctl        (timer_ctl),
      .load_value (load_value),
      .expired    (expired)
   );

   assign hb_limit = (hb_interval_ff == 16'd0) ? 16'd1 : hb_interval_ff;
   assign hb_next  = hb_count_ff + 16'd1;

   // Command decode and next station state.
   always_comb begin
      state_in      = state_ff;
      error_in      = error_ff;
      hb_count_in   = hb_count_ff;
      hb_running_in = hb_running_ff;
      acc           = 1'b0;
      hb            = thsm_pkg::HB_NONE;
      case (thsm_pkg::cmd_type'(req_data.cmd))
         thsm_pkg::CMD_TICK: begin
            acc = 1'b1;
            // Apply expiries before heartbeat pacing.
            for (int k = 0; k < thsm_pkg::NUM_KINDS; k++) begin
               if (expired[k] && (state_in == thsm_pkg::pend_state(2'(k)))) begin
                  state_in = thsm_pkg::kind_is_out(2'(k)) ? thsm_pkg::ST_WITH
                                                          : thsm_pkg::ST_WITHOUT;
                  error_in = thsm_pkg::timeout_error(2'(k));
               end
            end
            if (hb_running_ff) begin
               hb_count_in = hb_next;
               if (hb_next >= hb_limit) begin
                  hb_count_in = 16'd0;
                  if (state_in != thsm_pkg::ST_DISABLED) begin
                     hb = thsm_pkg::holds_token(state_in) ? thsm_pkg::HB_MASTER
                                                          : thsm_pkg::HB_SLAVE;
                  end
               end
            end
         end
         thsm_pkg::CMD_START: begin
            if (!req_data.bind_ok) begin
               state_in = thsm_pkg::ST_DISABLED;
               error_in = thsm_pkg::ERR_INNER;
            end else begin
               hb_running_in = 1'b1;
               hb_count_in   = 16'd0;
               if (error_ff != thsm_pkg::ERR_INNER) begin
                  state_in = thsm_pkg::ST_WITHOUT;
                  acc      = 1'b1;
               end else begin
                  state_in = thsm_pkg::ST_DISABLED;
               end
            end
         end
         thsm_pkg::CMD_STOP: begin
            hb_running_in = 1'b0;
            hb_count_in   = 16'd0;
            state_in      = thsm_pkg::ST_DISABLED;
            acc           = 1'b1;
         end
         thsm_pkg::CMD_REQUEST: begin
            if ((state_ff == home) && req_data.target_valid) begin
               state_in = pend;
               acc      = 1'b1;
            end
         end
         thsm_pkg::CMD_ACK: begin
            if (state_ff == pend) begin
               state_in = away;
               acc      = 1'b1;
            end
         end
         thsm_pkg::CMD_CANCEL: begin
            if (state_ff == pend) begin
               state_in = home;
               acc      = 1'b1;
            end
         end
         thsm_pkg::CMD_FORCE_IN: begin
            if ((state_ff != thsm_pkg::ST_DISABLED) && (error_ff != thsm_pkg::ERR_INNER)) begin
               state_in = thsm_pkg::ST_WITH;
               acc      = 1'b1;
            end
         end
         thsm_pkg::CMD_FORCE_OUT: begin
            if (state_ff != thsm_pkg::ST_DISABLED) begin
               state_in = thsm_pkg::ST_WITHOUT;
               acc      = 1'b1;
            end
         end
         default: begin
            acc = 1'b0;
         end
      endcase
   end

   // Response transaction built from the state after the command.
   always_comb begin
      rsp_data_in.accepted   = acc;
      rsp_data_in.peer_state = thsm_pkg::peer_code(state_in);
      rsp_data_in.error_code = error_in;
      rsp_data_in.has_token  = thsm_pkg::holds_token(state_in);
      rsp_data_in.heartbeat  = hb;
   end

   // Output register valid: load on accept, drop when taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Station state registers advance only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= thsm_pkg::ST_DISABLED;
         error_ff      <= thsm_pkg::ERR_NONE;
         hb_count_ff   <= 16'd0;
         hb_running_ff <= 1'b0;
      end else if (accept) begin
         state_ff      <= state_in;
         error_ff      <= error_in;
         hb_count_ff   <= hb_count_in;
         hb_running_ff <= hb_running_in;
      end
   end

   // Heartbeat interval register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_interval_ff <= thsm_pkg::HB_INTERVAL_RESET;
      end else if (csr_write_enable) begin
         hb_interval_ff <= csr_write_data;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/thsm_timers.sv]
// ----------------------------------------------------------------------------
// Handover timer bank
// One one-shot countdown per handover kind. A load arms one countdown, each
// tick decrements every running countdown, and an expiry flag is raised for
// a countdown that reaches zero on this tick.
// ----------------------------------------------------------------------------
module thsm_timers #(
   parameter int TIMEOUT_WIDTH = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  thsm_pkg::timer_ctl_type      ctl,
   input  logic [TIMEOUT_WIDTH-1:0]     load_value,
   output logic [thsm_pkg::NUM_KINDS-1:0] expired
);

   logic [TIMEOUT_WIDTH-1:0] count_ff [thsm_pkg::NUM_KINDS];
   logic [TIMEOUT_WIDTH-1:0] count_in [thsm_pkg::NUM_KINDS];

   // Next countdown values and expiry flags, one lane per kind.
   always_comb begin
      for (int k = 0; k < thsm_pkg::NUM_KINDS; k++) begin
         count_in[k] = count_ff[k];
         expired[k]  = 1'b0;
         if (ctl.load && (ctl.kind == 2'(k))) begin
            count_in[k] = load_value;
         end else if (ctl.tick && (count_ff[k] != '0)) begin
            count_in[k] = count_ff[k] - 1'b1;
            expired[k]  = (count_ff[k] == TIMEOUT_WIDTH'(1));
         end
      end
   end

   // Countdown registers; zero means inactive.
   always_ff @(posedge clock) begin
      for (int k = 0; k < thsm_pkg::NUM_KINDS; k++) begin
         if (reset) begin
            count_ff[k] <= '0;
         end else begin
            count_ff[k] <= count_in[k];
         end
      end
   end

endmodule

[dv/thsm_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Token handover scoreboard
// Predicts the response transaction of every accepted command and checks
// the block's responses against those predictions, oldest first.
// ----------------------------------------------------------------------------
package thsm_tb_pkg;

   import thsm_pkg::*;

   class handover_scoreboard;

      // Predicted station state, in reported peer codes.
      logic [2:0]  station_code;
      logic [2:0]  latched_err;
      logic [30:0] countdown [NUM_KINDS];
      logic [15:0] hb_count;
      logic [15:0] hb_interval;
      logic        hb_running;

      // Responses still owed by the block, oldest at the front.
      rsp_type expected_reports [$];

      int unsigned commands;
      int unsigned rejected;
      int unsigned timeout_reverts;
      int unsigned heartbeats;
      int unsigned reports_checked;
      int unsigned mismatches;

      function new();
         int k;
         station_code = PEER_DISABLED;
         latched_err  = ERR_NONE;
         for (k = 0; k < NUM_KINDS; k++) begin
            countdown[k] = '0;
         end
         hb_count        = '0;
         hb_interval     = HB_INTERVAL_RESET;
         hb_running      = 1'b0;
         commands        = 0;
         rejected        = 0;
         timeout_reverts = 0;
         heartbeats      = 0;
         reports_checked = 0;
         mismatches      = 0;
      endfunction

      function void set_interval(input logic [15:0] value);
         hb_interval = value;
      endfunction

      // The token stays here while held or while an out handover pends.
      function logic token_held(input logic [2:0] code);
         return (code == PEER_WITH) || (code == PEER_PEND_TO) || (code == PEER_PEND_OO);
      endfunction

      // Apply one command to the predicted state and build its response.
      function rsp_type predict_report(input req_type c);
         rsp_type    r;
         logic       out_kind;
         logic [2:0] pend;
         logic [2:0] home;
         logic [2:0] away;
         logic [15:0] limit;
         int         k;
         r        = '0;
         out_kind = ~c.kind[0];
         pend     = PEER_PEND_TO + {1'b0, c.kind};
         home     = out_kind ? PEER_WITH : PEER_WITHOUT;
         away     = out_kind ? PEER_WITHOUT : PEER_WITH;
         case (c.cmd)
            CMD_TICK: begin
               r.accepted = 1'b1;
               // Expiries come first; an expiry only matters while its kind pends.
               for (k = 0; k < NUM_KINDS; k++) begin
                  if (countdown[k] != '0) begin
                     countdown[k] = countdown[k] - 31'd1;
                     if (countdown[k] == '0 && station_code == PEER_PEND_TO + 3'(k)) begin
                        station_code = (k % 2 == 0) ? PEER_WITH : PEER_WITHOUT;
                        latched_err  = ERR_TIMEOUT_BASE + 3'(k);
                        timeout_reverts++;
                     end
                  end
               end
               // Heartbeat pacing; a zero interval behaves as one.
               if (hb_running) begin
                  limit    = (hb_interval == '0) ? 16'd1 : hb_interval;
                  hb_count = hb_count + 16'd1;
                  if (hb_count >= limit) begin
                     hb_count = '0;
                     if (station_code != PEER_DISABLED) begin
                        r.heartbeat = token_held(station_code) ? HB_MASTER : HB_SLAVE;
                        heartbeats++;
                     end
                  end
               end
            end
            CMD_START: begin
               if (!c.bind_ok) begin
                  station_code = PEER_DISABLED;
                  latched_err  = ERR_INNER;
               end else begin
                  hb_running = 1'b1;
                  hb_count   = '0;
                  if (latched_err != ERR_INNER) begin
                     station_code = PEER_WITHOUT;
                     r.accepted   = 1'b1;
                  end else begin
                     station_code = PEER_DISABLED;
                  end
               end
            end
            CMD_STOP: begin
               hb_running   = 1'b0;
               hb_count     = '0;
               station_code = PEER_DISABLED;
               r.accepted   = 1'b1;
            end
            CMD_REQUEST: begin
               if (station_code == home && c.target_valid) begin
                  station_code = pend;
                  if (c.timeout_ticks != '0) begin
                     countdown[c.kind] = c.timeout_ticks;
                  end
                  r.accepted = 1'b1;
               end
            end
            CMD_ACK: begin
               if (station_code == pend) begin
                  station_code = away;
                  r.accepted   = 1'b1;
               end
            end
            CMD_CANCEL: begin
               if (station_code == pend) begin
                  station_code = home;
                  r.accepted   = 1'b1;
               end
            end
            CMD_FORCE_IN: begin
               if (station_code != PEER_DISABLED && latched_err != ERR_INNER) begin
                  station_code = PEER_WITH;
                  r.accepted   = 1'b1;
               end
            end
            default: begin
               if (station_code != PEER_DISABLED) begin
                  station_code = PEER_WITHOUT;
                  r.accepted   = 1'b1;
               end
            end
         endcase
         r.peer_state = station_code;
         r.error_code = latched_err;
         r.has_token  = token_held(station_code);
         return r;
      endfunction

      // Record an accepted command transaction.
      function void note_command(input req_type c);
         rsp_type r;
         r = predict_report(c);
         expected_reports.push_back(r);
         commands++;
         if (!r.accepted) begin
            rejected++;
         end
      endfunction

      function void compare_field(input string field, input logic [2:0] want,
                                  input logic [2:0] got);
         if (got !== want) begin
            $display("%0t: response %0d, %s expected %0d actual %0d",
                     $time, reports_checked, field, want, got);
            mismatches++;
         end
      endfunction

      // Check one accepted response transaction against the oldest prediction.
      function void check_report(input rsp_type got);
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none actual %h",
                     $time, got);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("accepted", {2'b0, want.accepted}, {2'b0, got.accepted});
            compare_field("peer_state", want.peer_state, got.peer_state);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("has_token", {2'b0, want.has_token}, {2'b0, got.has_token});
            compare_field("heartbeat", {1'b0, want.heartbeat}, {1'b0, got.heartbeat});
         end
         reports_checked++;
      endfunction

      // Anything still owed at the end counts against the run.
      function void finish_check();
         if (expected_reports.size() != 0) begin
            $display("%0t: %0d responses expected but never seen, oldest expected %h actual none",
                     $time, expected_reports.size(), expected_reports[0]);
            mismatches += expected_reports.size();
         end
      endfunction

   endclass

endpackage

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Token handover state machine testbench
// Drives directed and random command transactions with random idling on
// both channels, across several heartbeat intervals, and checks every
// response against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_top;

   import thsm_pkg::*;
   import thsm_tb_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int NUM_PHASES     = 9;
   localparam int PHASE_ITEMS    = 140;
   localparam int HOLDOFF_ITEMS  = 30;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int FINAL_ITEMS    = 40;
   localparam logic [15:0] PHASE_INTERVAL [NUM_PHASES] = '{
      16'd1, 16'd65535, 16'd0, 16'd2, 16'd5, 16'd1000, 16'd7, 16'd13, 16'd4
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [15:0] csr_write_data;

   handover_scoreboard sb;
   logic        holdoff_pending;
   int unsigned holdoffs_done;
   int unsigned interval_writes;
   int unsigned cycle_count;

   token_handover_state_machine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up on a hung run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d responses outstanding",
                  $time, CYCLE_LIMIT, sb.expected_reports.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Every response transaction taken from the block is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_report(rsp_data);
      end
   end

   // Response side stalls: random stretches, plus a long hold-off on request.
   initial begin : response_stall
      int   roll;
      int   span;
      logic stall_value;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_pending) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_pending = 1'b0;
            holdoffs_done++;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               stall_value = 1'b0;
               span        = $urandom_range(50, 150);
            end else begin
               stall_value = ($urandom_range(0, 99) < 35);
               span        = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            end
            rsp_stall <= stall_value;
            repeat (span) @(posedge clock);
         end
      end
   end

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      else if (roll < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic logic [30:0] random_timeout();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return '0;
      else if (roll < 65) return 31'($urandom_range(1, 12));
      else if (roll < 85) return 31'($urandom_range(13, 300));
      else if (roll < 95) return 31'($urandom);
      else return 31'h7FFF_FFFF;
   endfunction

   function automatic req_type make_item(input logic [2:0] cmd, input logic [1:0] kind,
                                         input logic [30:0] tmo, input logic tv,
                                         input logic link_up);
      req_type c;
      c.cmd           = cmd;
      c.kind          = kind;
      c.timeout_ticks = tmo;
      c.target_valid  = tv;
      c.bind_ok       = link_up;
      return c;
   endfunction

   // Mostly well-formed handover sequences built on the predicted state,
   // with some noise. A failed bind is only allowed when asked for, since
   // the inner error it latches keeps the station disabled for good.
   function automatic req_type next_command(input logic allow_bind_fail);
      req_type c;
      int      roll;
      c.cmd           = CMD_TICK;
      c.kind          = 2'($urandom_range(0, 3));
      c.timeout_ticks = random_timeout();
      c.target_valid  = ($urandom_range(0, 9) != 0);
      c.bind_ok       = 1'($urandom_range(0, 1));
      roll            = $urandom_range(0, 99);
      if (sb.station_code == PEER_DISABLED && roll < 60) begin
         c.cmd = CMD_START;
      end else if (roll < 38) begin
         c.cmd = CMD_TICK;
      end else if (roll < 58) begin
         c.cmd = CMD_REQUEST;
         if ($urandom_range(0, 7) != 0) begin
            if (sb.station_code == PEER_WITH) c.kind = {1'($urandom_range(0, 1)), 1'b0};
            else if (sb.station_code == PEER_WITHOUT)
               c.kind = {1'($urandom_range(0, 1)), 1'b1};
         end
      end else if (roll < 76) begin
         c.cmd = ($urandom_range(0, 9) < 6) ? CMD_ACK : CMD_CANCEL;
         if (sb.station_code >= PEER_PEND_TO && $urandom_range(0, 7) != 0) begin
            c.kind = 2'(sb.station_code - PEER_PEND_TO);
         end
      end else if (roll < 84) begin
         c.cmd = $urandom_range(0, 1) ? CMD_FORCE_IN : CMD_FORCE_OUT;
      end else if (roll < 88) begin
         c.cmd = CMD_STOP;
      end else if (roll < 93) begin
         c.cmd = CMD_START;
      end else begin
         c.cmd = 3'($urandom_range(0, 7));
      end
      if (c.cmd == CMD_START && !allow_bind_fail) begin
         c.bind_ok = 1'b1;
      end
      return c;
   endfunction

   // Offer one command transaction after an optional idle gap.
   task automatic issue_command(input req_type c, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_command(c);
   endtask

   // Stop offering and wait until every predicted response has been seen.
   task automatic drain_reports();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_interval(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_interval(value);
      interval_writes++;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int          phase;
      int          n;
      logic        quiet;
      logic [15:0] interval;
      sb               = new();
      holdoff_pending  = 1'b0;
      holdoffs_done    = 0;
      interval_writes  = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every command, rejection and timeout case.
      write_interval(16'd3);
      issue_command(make_item(CMD_TICK, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_FORCE_IN, KIND_TAKE_OUT, '0, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_TAKE_IN, 31'd5, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_START, KIND_TAKE_OUT, '0, 1'b0, 1'b1), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_TAKE_OUT, 31'd4, 1'b1, 1'b0), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_TAKE_IN, 31'd4, 1'b0, 1'b1), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_TAKE_IN, 31'd2, 1'b1, 1'b0), idle_gap());
      issue_command(make_item(CMD_TICK, KIND_ORDER_IN, 31'h7FFF_FFFF, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_TICK, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_TICK, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_FORCE_IN, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_ORDER_OUT, 31'h7FFF_FFFF, 1'b1, 1'b1),
                    idle_gap());
      issue_command(make_item(CMD_ACK, KIND_ORDER_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_ACK, KIND_TAKE_IN, '0, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_ORDER_IN, '0, 1'b1, 1'b0), idle_gap());
      issue_command(make_item(CMD_CANCEL, KIND_ORDER_IN, '0, 1'b0, 1'b1), idle_gap());
      issue_command(make_item(CMD_FORCE_OUT, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_FORCE_IN, KIND_ORDER_IN, '0, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_TAKE_OUT, 31'd1, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_TICK, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_REQUEST, KIND_ORDER_OUT, 31'd2, 1'b1, 1'b0), idle_gap());
      issue_command(make_item(CMD_CANCEL, KIND_ORDER_OUT, '0, 1'b1, 1'b1), idle_gap());
      issue_command(make_item(CMD_TICK, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_TICK, KIND_TAKE_OUT, '0, 1'b0, 1'b0), idle_gap());
      issue_command(make_item(CMD_STOP, KIND_ORDER_IN, 31'h7FFF_FFFF, 1'b1, 1'b1),
                    idle_gap());

      // Random phases, one heartbeat interval each, written while idle.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_reports();
         interval = (phase == NUM_PHASES - 1) ? 16'($urandom_range(1, 65535))
                                              : PHASE_INTERVAL[phase];
         write_interval(interval);
         quiet = (phase % 3 == 2);
         // Hold the response side off so the block backs up into its input.
         if (phase == 1) begin
            holdoff_pending = 1'b1;
            for (n = 0; n < HOLDOFF_ITEMS; n++) begin
               issue_command(next_command(1'b0), 0);
            end
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            issue_command(next_command(1'b0), quiet ? 0 : idle_gap());
         end
      end

      // A failed bind latches the inner error; everything after runs disabled.
      drain_reports();
      issue_command(make_item(CMD_START, KIND_TAKE_OUT, '0, 1'b1, 1'b0), idle_gap());
      for (n = 0; n < FINAL_ITEMS; n++) begin
         issue_command(next_command(1'b1), idle_gap());
      end

      drain_reports();
      repeat (5) @(posedge clock);
      sb.finish_check();
      $display("Checked %0d responses to %0d commands: %0d rejected, %0d timeout reverts,",
               sb.reports_checked, sb.commands, sb.rejected, sb.timeout_reverts);
      $display("%0d heartbeats, %0d interval writes, %0d long response hold-offs.",
               sb.heartbeats, interval_writes, holdoffs_done);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/thsm_pkg.sv
rtl/thsm_timers.sv
rtl/token_handover_state_machine.sv
dv/thsm_tb_pkg.sv
dv/tb_top.sv
